@@ src/gcsp_pkg.sv @@
// Shared constants for the gait command to servo packet block.
// Frame and packet byte codes, register indexes, reset values and the amplitude map.
// No dependencies.
package gcsp_pkg;

    localparam int PHASE_BITS_DEF     = 16;
    localparam int SINE_ENTRIES_DEF   = 256;
    localparam int FRAME_LENGTH       = 6;
    localparam int PARAM_VALUES       = 256;

    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    localparam logic [7:0] FRAME_HEAD0 = 8'hFF;
    localparam logic [7:0] FRAME_HEAD1 = 8'hFA;
    localparam logic [7:0] FRAME_TAIL0 = 8'h88;
    localparam logic [7:0] FRAME_TAIL1 = 8'h77;

    localparam logic [7:0] PKT_HEAD0   = 8'h12;
    localparam logic [7:0] PKT_HEAD1   = 8'h4C;
    localparam logic [7:0] CMD_MOVE    = 8'h0C;
    localparam logic [7:0] CMD_HOLD    = 8'h18;
    localparam logic [7:0] HOLD_MODE   = 8'h11;
    localparam logic [7:0] MOVE_LEN    = 8'd11;
    localparam logic [7:0] HOLD_LEN    = 8'd4;
    localparam logic [7:0] MOVE_CONST  = 8'(PKT_HEAD0 + PKT_HEAD1 + CMD_MOVE + MOVE_LEN);
    localparam logic [7:0] HOLD_CONST  = 8'(PKT_HEAD0 + PKT_HEAD1 + CMD_HOLD + HOLD_LEN
                                            + HOLD_MODE);
    localparam int         PKT_MAX     = 16;
    localparam logic [4:0] MOVE_BYTES  = 5'd16;
    localparam logic [4:0] HOLD_BYTES  = 5'd9;

    localparam logic [7:0] MODE_STOP   = 8'h00;
    localparam logic [7:0] MODE_CRAWL  = 8'h01;
    localparam logic [7:0] MODE_SNAKE  = 8'h02;
    localparam logic [7:0] MODE_DIRECT = 8'h10;
    localparam logic [7:0] MODE_CENTER = 8'h11;
    localparam logic [7:0] CRAWL_STOP_PARAM = 8'h08;

    localparam logic [2:0] REG_SERVO_ID   = 3'd0;
    localparam logic [2:0] REG_PERIOD     = 3'd1;
    localparam logic [2:0] REG_PHASE_STEP = 3'd2;
    localparam logic [2:0] REG_MAX_OFFSET = 3'd3;
    localparam logic [2:0] REG_SPEED      = 3'd4;
    localparam logic [2:0] REG_ACCEL      = 3'd5;
    localparam logic [2:0] REG_DECEL      = 3'd6;
    localparam logic [2:0] REG_POWER      = 3'd7;

    localparam logic [7:0]  SERVO_ID_RST   = 8'd6;
    localparam logic [15:0] PERIOD_RST     = 16'd50;
    localparam logic [15:0] PHASE_STEP_RST = 16'd655;
    localparam logic [10:0] MAX_OFFSET_RST = 11'd450;
    localparam logic [15:0] SPEED_RST      = 16'd300;
    localparam logic [15:0] ACCEL_RST      = 16'd100;
    localparam logic [15:0] DECEL_RST      = 16'd100;
    localparam logic [15:0] POWER_RST      = 16'd6000;

    localparam logic [1:0] OP_HOLD        = 2'd0;
    localparam logic [1:0] OP_MOVE_SINE   = 2'd1;
    localparam logic [1:0] OP_MOVE_DIRECT = 2'd2;
    localparam logic [1:0] OP_MOVE_ZERO   = 2'd3;

    function automatic logic [10:0] amp_of(input int unsigned p);
        int unsigned v;
        v = (p * 1800 + 255) / 510;
        return 11'(v);
    endfunction

endpackage

@@ src/gait_command_to_servo_packets.sv @@
// Gait command to servo packets: frame parser, sine gait and packet serializer.
// Depends on gcsp_pkg.
//
// Each accepted beat is a host byte or a millisecond tick. Host bytes are parsed as
// FF FA mode param 88 77 frames; ticks step the sine gait every period_ms ticks. A beat
// that yields a packet passes three register stages (table lookup and multiply, scaling,
// clamp and checksum) and lands in a 16-byte output shift register. Bytes then leave
// one per cycle while out_ready is high: a hold packet is 9 bytes and a move packet 16,
// and that output shift register sets the sustained rate. Input beats are taken every
// cycle while the stages have room, also while a packet is still going out; beats that
// yield no packet never enter the stages.
module gait_command_to_servo_packets
    import gcsp_pkg::*;
#(
    parameter int PHASE_BITS         = PHASE_BITS_DEF,
    parameter int SINE_TABLE_ENTRIES = SINE_ENTRIES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  tx_byte,
    output logic        last_byte,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int IDX_W  = $clog2(SINE_TABLE_ENTRIES);
    localparam int PROD_W = PHASE_BITS + $clog2(SINE_TABLE_ENTRIES + 1);

    localparam logic [2:0] FP_IDLE  = 3'd0;
    localparam logic [2:0] FP_HEAD  = 3'd1;
    localparam logic [2:0] FP_MODE  = 3'd2;
    localparam logic [2:0] FP_PARAM = 3'd3;
    localparam logic [2:0] FP_TAIL0 = 3'd4;
    localparam logic [2:0] FP_TAIL1 = 3'(FRAME_LENGTH - 1);

    function automatic logic signed [15:0] sine_value(input longint unsigned k);
        longint unsigned four, q, r, x, x2, t, s, mag;
        four = 4 * k;
        q = four / SINE_TABLE_ENTRIES;
        r = four - q * SINE_TABLE_ENTRIES;
        if (q[0])
        begin
            r = SINE_TABLE_ENTRIES - r;
        end
        x = r * HALF_PI_Q30 / SINE_TABLE_ENTRIES;
        x2 = (x * x) >> 30;
        t = Q30_ONE - x2 / 72;
        t = Q30_ONE - ((x2 * t) >> 30) / 42;
        t = Q30_ONE - ((x2 * t) >> 30) / 20;
        t = Q30_ONE - ((x2 * t) >> 30) / 6;
        s = (x * t) >> 30;
        mag = (s * 32767 + (64'd1 << 29)) >> 30;
        if (mag > 32767)
        begin
            mag = 32767;
        end
        return q[1] ? -16'(mag) : 16'(mag);
    endfunction

    logic signed [15:0] sine_lut [SINE_TABLE_ENTRIES];
    logic [10:0]        amp_lut  [PARAM_VALUES];

    for (genvar g = 0; g < SINE_TABLE_ENTRIES; g++)
    begin : g_sine
        assign sine_lut[g] = sine_value(g);
    end

    for (genvar g = 0; g < PARAM_VALUES; g++)
    begin : g_amp
        assign amp_lut[g] = amp_of(g);
    end

    // configuration
    logic [7:0]  servo_id_reg;
    logic [15:0] period_reg;
    logic [15:0] phase_step_reg;
    logic [10:0] max_offset_reg;
    logic [15:0] speed_reg;
    logic [15:0] accel_reg;
    logic [15:0] decel_reg;
    logic [15:0] power_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            servo_id_reg   <= SERVO_ID_RST;
            period_reg     <= PERIOD_RST;
            phase_step_reg <= PHASE_STEP_RST;
            max_offset_reg <= MAX_OFFSET_RST;
            speed_reg      <= SPEED_RST;
            accel_reg      <= ACCEL_RST;
            decel_reg      <= DECEL_RST;
            power_reg      <= POWER_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_SERVO_ID:   servo_id_reg   <= cfg_data[7:0];
                REG_PERIOD:     period_reg     <= cfg_data;
                REG_PHASE_STEP: phase_step_reg <= cfg_data;
                REG_MAX_OFFSET: max_offset_reg <= cfg_data[10:0];
                REG_SPEED:      speed_reg      <= cfg_data;
                REG_ACCEL:      accel_reg      <= cfg_data;
                REG_DECEL:      decel_reg      <= cfg_data;
                REG_POWER:      power_reg      <= cfg_data;
                default:        servo_id_reg   <= servo_id_reg;
            endcase
        end
    end

    // parser and gait state
    logic [2:0]            frame_pos_reg, frame_pos_next;
    logic [7:0]            mode_reg;
    logic [7:0]            param_reg;
    logic [7:0]            tail_reg;
    logic                  gait_en_reg, gait_en_next;
    logic [10:0]           amp_reg, amp_next;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic [15:0]           elapsed_reg, elapsed_next;
    logic [15:0]           elapsed_inc;
    logic [10:0]           snake_amp;
    logic                  push;
    logic [1:0]            push_op;
    logic                  in_fire;

    // pipeline stages
    logic                  s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [1:0]            s1_op_reg, s2_op_reg, s3_op_reg;
    logic [PHASE_BITS-1:0] s1_phase_reg;
    logic [10:0]           s1_amp_reg;
    logic [7:0]            s1_param_reg;
    logic                  s2_neg_reg, s3_neg_reg;
    logic [25:0]           s2_prod_reg;
    logic [12:0]           s3_q_reg;
    logic [19:0]           s3_w_reg;
    logic [7:0]            s3_base_reg;

    logic [7:0]            pkt_reg [PKT_MAX];
    logic [4:0]            left_reg;

    logic out_fire, buf_free;
    logic s1_adv, s2_adv, s3_adv, s1_free, s2_free, s3_free;

    assign out_fire = out_valid && out_ready;
    assign buf_free = (left_reg == 5'd0) || ((left_reg == 5'd1) && out_fire);
    assign s3_adv   = s3_valid_reg && buf_free;
    assign s3_free  = !s3_valid_reg || s3_adv;
    assign s2_adv   = s2_valid_reg && s3_free;
    assign s2_free  = !s2_valid_reg || s2_adv;
    assign s1_adv   = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || s1_adv;
    assign in_ready = s1_free;
    assign in_fire  = in_valid && in_ready;

    assign elapsed_inc = (elapsed_reg != 16'hFFFF) ? elapsed_reg + 16'd1 : elapsed_reg;
    assign snake_amp   = (amp_lut[param_reg] > max_offset_reg) ? max_offset_reg
                                                                : amp_lut[param_reg];

    always_comb
    begin
        frame_pos_next = frame_pos_reg;
        gait_en_next   = gait_en_reg;
        amp_next       = amp_reg;
        phase_next     = phase_reg;
        elapsed_next   = elapsed_reg;
        push           = 1'b0;
        push_op        = OP_HOLD;
        if (in_fire)
        begin
            if (command)
            begin
                if (gait_en_reg && (elapsed_inc >= period_reg))
                begin
                    elapsed_next = 16'd0;
                    phase_next   = phase_reg + PHASE_BITS'(phase_step_reg);
                    push         = 1'b1;
                    push_op      = OP_MOVE_SINE;
                end
                else
                begin
                    elapsed_next = elapsed_inc;
                end
            end
            else
            begin
                case (frame_pos_reg)
                    FP_IDLE:
                    begin
                        if (data_byte == FRAME_HEAD0)
                        begin
                            frame_pos_next = FP_HEAD;
                        end
                    end
                    FP_HEAD:
                    begin
                        if (data_byte == FRAME_HEAD1)
                        begin
                            frame_pos_next = FP_MODE;
                        end
                        else if (data_byte == FRAME_HEAD0)
                        begin
                            frame_pos_next = FP_HEAD;
                        end
                        else
                        begin
                            frame_pos_next = FP_IDLE;
                        end
                    end
                    FP_MODE:  frame_pos_next = FP_PARAM;
                    FP_PARAM: frame_pos_next = FP_TAIL0;
                    FP_TAIL0: frame_pos_next = FP_TAIL1;
                    FP_TAIL1:
                    begin
                        frame_pos_next = FP_IDLE;
                        if ((tail_reg == FRAME_TAIL0) && (data_byte == FRAME_TAIL1))
                        begin
                            case (mode_reg)
                                MODE_STOP:
                                begin
                                    gait_en_next = 1'b0;
                                    push         = 1'b1;
                                    push_op      = OP_HOLD;
                                end
                                MODE_CRAWL:
                                begin
                                    if (param_reg == CRAWL_STOP_PARAM)
                                    begin
                                        gait_en_next = 1'b0;
                                        push         = 1'b1;
                                        push_op      = OP_HOLD;
                                    end
                                end
                                MODE_SNAKE:
                                begin
                                    push = 1'b1;
                                    if (param_reg == 8'd0)
                                    begin
                                        gait_en_next = 1'b0;
                                        push_op      = OP_HOLD;
                                    end
                                    else
                                    begin
                                        amp_next     = snake_amp;
                                        phase_next   = '0;
                                        gait_en_next = 1'b1;
                                        elapsed_next = 16'd0;
                                        push_op      = OP_MOVE_ZERO;
                                    end
                                end
                                MODE_DIRECT:
                                begin
                                    gait_en_next = 1'b0;
                                    push         = 1'b1;
                                    push_op      = OP_MOVE_DIRECT;
                                end
                                MODE_CENTER:
                                begin
                                    gait_en_next = 1'b0;
                                    push         = 1'b1;
                                    push_op      = OP_MOVE_ZERO;
                                end
                                default:
                                begin
                                    push = 1'b0;
                                end
                            endcase
                        end
                    end
                    default: frame_pos_next = FP_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_pos_reg <= FP_IDLE;
            gait_en_reg   <= 1'b0;
            amp_reg       <= 11'd0;
            phase_reg     <= '0;
            elapsed_reg   <= 16'd0;
        end
        else
        begin
            frame_pos_reg <= frame_pos_next;
            gait_en_reg   <= gait_en_next;
            amp_reg       <= amp_next;
            phase_reg     <= phase_next;
            elapsed_reg   <= elapsed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && !command)
        begin
            if (frame_pos_reg == FP_MODE)
            begin
                mode_reg <= data_byte;
            end
            if (frame_pos_reg == FP_PARAM)
            begin
                param_reg <= data_byte;
            end
            if (frame_pos_reg == FP_TAIL0)
            begin
                tail_reg <= data_byte;
            end
        end
    end

    // stage 1: table lookup and multiply
    logic [PROD_W-1:0]  idx_prod;
    logic [IDX_W-1:0]   sine_idx;
    logic signed [15:0] sine_ent;
    logic               ent_neg;
    logic [14:0]        ent_mag;
    logic [8:0]         two_p;
    logic               dir_neg;
    logic [7:0]         dir_mag;
    logic [14:0]        mul_a;
    logic [10:0]        mul_b;
    logic [25:0]        prod;

    assign idx_prod = PROD_W'(s1_phase_reg) * PROD_W'(SINE_TABLE_ENTRIES);
    assign sine_idx = IDX_W'(idx_prod >> PHASE_BITS);
    assign sine_ent = sine_lut[sine_idx];
    assign ent_neg  = sine_ent[15];
    assign ent_mag  = ent_neg ? 15'(-sine_ent) : 15'(sine_ent);
    assign two_p    = {s1_param_reg, 1'b0};
    assign dir_neg  = (s1_param_reg < 8'd128);
    assign dir_mag  = dir_neg ? 8'(9'd255 - two_p) : 8'(two_p - 9'd255);
    assign mul_a    = (s1_op_reg == OP_MOVE_SINE) ? ent_mag : 15'(dir_mag);
    assign mul_b    = (s1_op_reg == OP_MOVE_SINE) ? s1_amp_reg : max_offset_reg;
    assign prod     = 26'(mul_a) * 26'(mul_b);

    // stage 2: scale down and sum the fixed checksum bytes
    logic [12:0] sine_q;
    logic [19:0] dir_w;
    logic [37:0] dir_scaled;
    logic [12:0] dir_q0;
    logic [12:0] q_sel;
    logic [7:0]  move_base;
    logic [7:0]  hold_base;

    assign sine_q     = 13'((s2_prod_reg + 26'd16384) >> 15);
    assign dir_w      = 20'(s2_prod_reg[18:0]) + 20'd127;
    assign dir_scaled = (38'(dir_w) << 16) + (38'(dir_w) << 8) + 38'(dir_w);
    assign dir_q0     = 13'(dir_scaled >> 24);
    assign move_base  = MOVE_CONST + servo_id_reg + speed_reg[7:0] + speed_reg[15:8]
                        + accel_reg[7:0] + accel_reg[15:8] + decel_reg[7:0]
                        + decel_reg[15:8] + power_reg[7:0] + power_reg[15:8];
    assign hold_base  = HOLD_CONST + servo_id_reg + power_reg[7:0] + power_reg[15:8];

    always_comb
    begin
        case (s2_op_reg)
            OP_MOVE_SINE:   q_sel = sine_q;
            OP_MOVE_DIRECT: q_sel = dir_q0;
            default:        q_sel = 13'd0;
        endcase
    end

    // stage 3: correct quotient, clamp, negate, build packet
    logic [20:0] q255;
    logic [20:0] rem;
    logic        corr;
    logic [12:0] mag;
    logic [12:0] lim;
    logic [12:0] mag_c;
    logic [15:0] pos;
    logic [7:0]  csum;
    logic [7:0]  pkt_next [PKT_MAX];

    assign q255  = 21'({s3_q_reg, 8'b0}) - 21'(s3_q_reg);
    assign rem   = 21'(s3_w_reg) - q255;
    assign corr  = (s3_op_reg == OP_MOVE_DIRECT) && (rem >= 21'd255);
    assign mag   = s3_q_reg + 13'(corr);
    assign lim   = 13'(max_offset_reg);
    assign mag_c = (mag > lim) ? lim : mag;
    assign pos   = s3_neg_reg ? 16'(mag_c) : 16'd0 - 16'(mag_c);
    assign csum  = s3_base_reg + pos[7:0] + pos[15:8];

    always_comb
    begin
        for (int i = 0; i < PKT_MAX; i++)
        begin
            pkt_next[i] = 8'd0;
        end
        pkt_next[0] = PKT_HEAD0;
        pkt_next[1] = PKT_HEAD1;
        if (s3_op_reg == OP_HOLD)
        begin
            pkt_next[2] = CMD_HOLD;
            pkt_next[3] = HOLD_LEN;
            pkt_next[4] = servo_id_reg;
            pkt_next[5] = HOLD_MODE;
            pkt_next[6] = power_reg[7:0];
            pkt_next[7] = power_reg[15:8];
            pkt_next[8] = s3_base_reg;
        end
        else
        begin
            pkt_next[2]  = CMD_MOVE;
            pkt_next[3]  = MOVE_LEN;
            pkt_next[4]  = servo_id_reg;
            pkt_next[5]  = pos[7:0];
            pkt_next[6]  = pos[15:8];
            pkt_next[7]  = speed_reg[7:0];
            pkt_next[8]  = speed_reg[15:8];
            pkt_next[9]  = accel_reg[7:0];
            pkt_next[10] = accel_reg[15:8];
            pkt_next[11] = decel_reg[7:0];
            pkt_next[12] = decel_reg[15:8];
            pkt_next[13] = power_reg[7:0];
            pkt_next[14] = power_reg[15:8];
            pkt_next[15] = csum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            left_reg     <= 5'd0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= push;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s3_adv)
            begin
                left_reg <= (s3_op_reg == OP_HOLD) ? HOLD_BYTES : MOVE_BYTES;
            end
            else if (out_fire)
            begin
                left_reg <= left_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && s1_free)
        begin
            s1_op_reg    <= push_op;
            s1_phase_reg <= phase_next;
            s1_amp_reg   <= amp_next;
            s1_param_reg <= param_reg;
        end
        if (s1_adv)
        begin
            s2_op_reg   <= s1_op_reg;
            s2_neg_reg  <= (s1_op_reg == OP_MOVE_SINE) ? ent_neg : dir_neg;
            s2_prod_reg <= prod;
        end
        if (s2_adv)
        begin
            s3_op_reg   <= s2_op_reg;
            s3_neg_reg  <= s2_neg_reg;
            s3_q_reg    <= q_sel;
            s3_w_reg    <= dir_w;
            s3_base_reg <= (s2_op_reg == OP_HOLD) ? hold_base : move_base;
        end
        if (s3_adv)
        begin
            for (int i = 0; i < PKT_MAX; i++)
            begin
                pkt_reg[i] <= pkt_next[i];
            end
        end
        else if (out_fire)
        begin
            // advance the byte shift line
            for (int i = 0; i < PKT_MAX - 1; i++)
            begin
                pkt_reg[i] <= pkt_reg[i + 1];
            end
        end
    end

    assign out_valid = (left_reg != 5'd0);
    assign tx_byte   = pkt_reg[0];
    assign last_byte = (left_reg == 5'd1);

endmodule

@@ tb/sv/gait_command_to_servo_packets_check.sv @@
// Checker for gait_command_to_servo_packets: watches the input, output and register ports,
// predicts every servo packet byte and compares it with what the block sends.
// Depends on gcsp_pkg.
module gait_command_to_servo_packets_check
    import gcsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        command,
    input  logic [7:0]  data_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  tx_byte,
    input  logic        last_byte,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending_bytes
);

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } pkt_byte_t;

    pkt_byte_t   tx_expect[$];
    pkt_byte_t   want;
    int          mismatches;
    logic [7:0]  pkt_sum;

    logic [7:0]  id_r;
    logic [15:0] period_r;
    logic [15:0] step_r;
    logic [10:0] maxoff_r;
    logic [15:0] speed_r;
    logic [15:0] accel_r;
    logic [15:0] decel_r;
    logic [15:0] power_r;

    logic [2:0]  frame_pos;
    logic [7:0]  frame_bytes [4];
    logic        gait_on;
    logic [10:0] amp;
    logic [15:0] phase;
    logic [15:0] elapsed;

    function automatic int signed sine_q15(input logic [15:0] ph);
        longint unsigned n, k, four, q, r, x, x2, t, s, mag;
        n    = SINE_ENTRIES_DEF;
        k    = ({48'd0, ph} * n) >> PHASE_BITS_DEF;
        k    = k % n;
        four = 4 * k;
        q    = four / n;
        r    = four - q * n;
        if (q[0])
            r = n - r;
        x    = r * HALF_PI_Q30 / n;
        x2   = (x * x) >> 30;
        t    = Q30_ONE - x2 / 72;
        t    = Q30_ONE - ((x2 * t) >> 30) / 42;
        t    = Q30_ONE - ((x2 * t) >> 30) / 20;
        t    = Q30_ONE - ((x2 * t) >> 30) / 6;
        s    = (x * t) >> 30;
        mag  = (s * 32767 + (64'd1 << 29)) >> 30;
        if (mag > 32767)
            mag = 32767;
        return q[1] ? -int'(mag) : int'(mag);
    endfunction

    task automatic add_byte(input logic [7:0] b);
        tx_expect.push_back('{value: b, last: 1'b0});
        pkt_sum = pkt_sum + b;
    endtask

    task automatic add_word(input logic [15:0] w);
        add_byte(w[7:0]);
        add_byte(w[15:8]);
    endtask

    task automatic start_packet(input logic [7:0] cmd, input logic [7:0] len);
        pkt_sum = 8'd0;
        add_byte(PKT_HEAD0);
        add_byte(PKT_HEAD1);
        add_byte(cmd);
        add_byte(len);
        add_byte(id_r);
    endtask

    task automatic close_packet;
        tx_expect.push_back('{value: pkt_sum, last: 1'b1});
    endtask

    task automatic queue_hold;
        start_packet(CMD_HOLD, HOLD_LEN);
        add_byte(HOLD_MODE);
        add_word(power_r);
        close_packet();
    endtask

    task automatic queue_move(input int signed offset);
        int signed lim;
        int signed pos;
        lim = maxoff_r;
        if (offset > lim)
            offset = lim;
        if (offset < -lim)
            offset = -lim;
        pos = -offset;
        start_packet(CMD_MOVE, MOVE_LEN);
        add_word(pos[15:0]);
        add_word(speed_r);
        add_word(accel_r);
        add_word(decel_r);
        add_word(power_r);
        close_packet();
    endtask

    task automatic run_mode(input logic [7:0] mode, input logic [7:0] p);
        int unsigned v;
        int signed   num;
        int signed   mag;
        case (mode)
            MODE_STOP:
            begin
                gait_on = 1'b0;
                queue_hold();
            end
            MODE_CRAWL:
            begin
                if (p == CRAWL_STOP_PARAM)
                begin
                    gait_on = 1'b0;
                    queue_hold();
                end
            end
            MODE_SNAKE:
            begin
                if (p == 8'd0)
                begin
                    gait_on = 1'b0;
                    queue_hold();
                end
                else
                begin
                    v = (p * 1800 + 255) / 510;
                    if (v > maxoff_r)
                        v = maxoff_r;
                    amp     = v[10:0];
                    phase   = 16'd0;
                    gait_on = 1'b1;
                    elapsed = 16'd0;
                    queue_move(0);
                end
            end
            MODE_DIRECT:
            begin
                num     = (2 * int'(p) - 255) * int'(maxoff_r);
                mag     = ((num < 0 ? -num : num) * 2 + 255) / 510;
                gait_on = 1'b0;
                queue_move(num < 0 ? -mag : mag);
            end
            MODE_CENTER:
            begin
                gait_on = 1'b0;
                queue_move(0);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic take_beat(input logic is_tick, input logic [7:0] b);
        int signed   s;
        int unsigned prod;
        int signed   mag;
        if (is_tick)
        begin
            if (elapsed != 16'hFFFF)
                elapsed = elapsed + 16'd1;
            if (gait_on && elapsed >= period_r)
            begin
                elapsed = 16'd0;
                phase   = phase + step_r;
                s       = sine_q15(phase);
                prod    = amp * (s < 0 ? -s : s) + 16384;
                mag     = prod >> 15;
                queue_move(s < 0 ? -mag : mag);
            end
        end
        else if (frame_pos == 3'd0)
        begin
            if (b == FRAME_HEAD0)
                frame_pos = 3'd1;
        end
        else if (frame_pos == 3'd1 && b != FRAME_HEAD1)
        begin
            frame_pos = (b == FRAME_HEAD0) ? 3'd1 : 3'd0;
        end
        else
        begin
            if (frame_pos >= 3'd2)
                frame_bytes[2'(frame_pos - 3'd2)] = b;
            frame_pos = frame_pos + 3'd1;
            if (frame_pos == 3'(FRAME_LENGTH))
            begin
                frame_pos = 3'd0;
                if (frame_bytes[2] == FRAME_TAIL0 && frame_bytes[3] == FRAME_TAIL1)
                    run_mode(frame_bytes[0], frame_bytes[1]);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_r          = SERVO_ID_RST;
            period_r      = PERIOD_RST;
            step_r        = PHASE_STEP_RST;
            maxoff_r      = MAX_OFFSET_RST;
            speed_r       = SPEED_RST;
            accel_r       = ACCEL_RST;
            decel_r       = DECEL_RST;
            power_r       = POWER_RST;
            frame_pos     = 3'd0;
            gait_on       = 1'b0;
            amp           = 11'd0;
            phase         = 16'd0;
            elapsed       = 16'd0;
            mismatches    = 0;
            tx_expect.delete();
            fail_count    <= 0;
            pending_bytes <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_SERVO_ID:   id_r     = cfg_data[7:0];
                    REG_PERIOD:     period_r = cfg_data;
                    REG_PHASE_STEP: step_r   = cfg_data;
                    REG_MAX_OFFSET: maxoff_r = cfg_data[10:0];
                    REG_SPEED:      speed_r  = cfg_data;
                    REG_ACCEL:      accel_r  = cfg_data;
                    REG_DECEL:      decel_r  = cfg_data;
                    REG_POWER:      power_r  = cfg_data;
                    default:        ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (tx_expect.size() == 0)
                begin
                    $error("tx_byte unexpected: expected none, actual %02h", tx_byte);
                    mismatches++;
                end
                else
                begin
                    want = tx_expect.pop_front();
                    if (tx_byte !== want.value)
                    begin
                        $error("tx_byte mismatch: expected %02h, actual %02h",
                               want.value, tx_byte);
                        mismatches++;
                    end
                    if (last_byte !== want.last)
                    begin
                        $error("last_byte mismatch: expected %0b, actual %0b",
                               want.last, last_byte);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
                take_beat(command, data_byte);
            fail_count    <= mismatches;
            pending_bytes <= tx_expect.size();
        end
    end

endmodule

@@ tb/sv/gait_command_to_servo_packets_test.sv @@
// Top of the gait_command_to_servo_packets testbench: clock, reset, register writes,
// host byte and tick stimulus with random stalls on both sides, and the verdict.
// Depends on gcsp_pkg, the block and gait_command_to_servo_packets_check.
module gait_command_to_servo_packets_test;
    import gcsp_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        command;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  tx_byte;
    logic        last_byte;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    int          check_fails;
    int          check_pending;
    int          beats_sent;
    bit          idling;
    bit          stall_long;

    gait_command_to_servo_packets u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .data_byte (data_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .tx_byte   (tx_byte),
        .last_byte (last_byte),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    gait_command_to_servo_packets_check u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .tx_byte       (tx_byte),
        .last_byte     (last_byte),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (check_fails),
        .pending_bytes (check_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic push_beat(input logic is_tick, input logic [7:0] b);
        if (idling && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        command   <= is_tick;
        data_byte <= b;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        beats_sent++;
    endtask

    task automatic send_frame(input logic [7:0] mode, input logic [7:0] p,
                              input logic [7:0] t0, input logic [7:0] t1);
        push_beat(1'b0, FRAME_HEAD0);
        push_beat(1'b0, FRAME_HEAD1);
        push_beat(1'b0, mode);
        push_beat(1'b0, p);
        push_beat(1'b0, t0);
        push_beat(1'b0, t1);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) push_beat(1'b1, 8'($urandom));
    endtask

    task automatic settle;
        in_valid <= 1'b0;
        @(posedge clk);
        while (check_pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_regs(input logic [15:0] id, input logic [15:0] period,
                              input logic [15:0] step, input logic [15:0] maxoff,
                              input logic [15:0] speed, input logic [15:0] accel,
                              input logic [15:0] decel, input logic [15:0] power);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_SERVO_ID;
        cfg_data  <= id;
        @(posedge clk);
        cfg_index <= REG_PERIOD;
        cfg_data  <= period;
        @(posedge clk);
        cfg_index <= REG_PHASE_STEP;
        cfg_data  <= step;
        @(posedge clk);
        cfg_index <= REG_MAX_OFFSET;
        cfg_data  <= maxoff;
        @(posedge clk);
        cfg_index <= REG_SPEED;
        cfg_data  <= speed;
        @(posedge clk);
        cfg_index <= REG_ACCEL;
        cfg_data  <= accel;
        @(posedge clk);
        cfg_index <= REG_DECEL;
        cfg_data  <= decel;
        @(posedge clk);
        cfg_index <= REG_POWER;
        cfg_data  <= power;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_traffic(input int n);
        int         first;
        logic [7:0] mode;
        logic [7:0] p;
        first = beats_sent;
        while (beats_sent - first < n)
        begin
            case ($urandom_range(0, 5))
                0:       mode = MODE_STOP;
                1:       mode = MODE_CRAWL;
                2:       mode = MODE_SNAKE;
                3:       mode = MODE_DIRECT;
                4:       mode = MODE_CENTER;
                default: mode = 8'($urandom);
            endcase
            p = 8'($urandom);
            if ($urandom_range(0, 3) == 0)
            begin
                case (mode)
                    MODE_CRAWL:  p = CRAWL_STOP_PARAM;
                    MODE_SNAKE:  p = 8'd0;
                    MODE_DIRECT: p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    default:     ;
                endcase
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                    send_frame(mode, p, FRAME_TAIL0, FRAME_TAIL1);
                5, 6:
                    send_ticks($urandom_range(0, 9) == 0 ? $urandom_range(1, 60)
                                                         : $urandom_range(1, 8));
                7:
                    push_beat(1'b0, 8'($urandom));
                8:
                begin
                    push_beat(1'b0, FRAME_HEAD0);
                    push_beat(1'b0, FRAME_HEAD1);
                    push_beat(1'b0, mode);
                end
                default:
                    send_frame(mode, p, 8'($urandom), $urandom_range(0, 1) ? FRAME_TAIL1
                                                                           : 8'($urandom));
            endcase
        end
    endtask

    initial
    begin
        out_ready = 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever
        begin
            if (stall_long)
            begin
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                stall_long = 1'b0;
            end
            else if (idling && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        command    = 1'b0;
        data_byte  = 8'd0;
        cfg_wr_en  = 1'b0;
        cfg_index  = REG_SERVO_ID;
        cfg_data   = 16'd0;
        beats_sent = 0;
        idling     = 1'b1;
        stall_long = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_beat(1'b0, 8'h00);
        push_beat(1'b0, 8'h7F);
        push_beat(1'b0, FRAME_HEAD0);
        send_frame(MODE_STOP, 8'h00, FRAME_TAIL0, FRAME_TAIL1);
        send_frame(MODE_STOP, 8'h00, FRAME_TAIL0, 8'h76);
        send_frame(MODE_CENTER, 8'h00, 8'h89, FRAME_TAIL1);
        send_frame(MODE_CRAWL, CRAWL_STOP_PARAM, FRAME_TAIL0, FRAME_TAIL1);
        send_frame(MODE_CRAWL, 8'h07, FRAME_TAIL0, FRAME_TAIL1);
        send_frame(MODE_SNAKE, 8'h00, FRAME_TAIL0, FRAME_TAIL1);
        send_frame(MODE_SNAKE, 8'hFF, FRAME_TAIL0, FRAME_TAIL1);
        send_ticks(50);
        send_frame(MODE_DIRECT, 8'h00, FRAME_TAIL0, FRAME_TAIL1);
        send_frame(MODE_DIRECT, 8'hFF, FRAME_TAIL0, FRAME_TAIL1);
        send_frame(MODE_DIRECT, 8'h80, FRAME_TAIL0, FRAME_TAIL1);
        send_frame(MODE_CENTER, 8'h5A, FRAME_TAIL0, FRAME_TAIL1);
        send_frame(8'h03, 8'h00, FRAME_TAIL0, FRAME_TAIL1);
        send_frame(8'hFF, 8'hFF, FRAME_TAIL0, FRAME_TAIL1);
        random_traffic(20);

        settle();
        write_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        random_traffic(20);

        settle();
        write_regs(16'd255, 16'd1, 16'hFFFF, 16'd1800,
                   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        random_traffic(20);

        settle();
        write_regs(16'($urandom_range(0, 255)), 16'd3, 16'($urandom), 16'hFFFF,
                   16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        random_traffic(20);

        settle();
        write_regs(16'($urandom_range(0, 255)), 16'hFFFF, 16'($urandom),
                   16'($urandom_range(0, 1800)),
                   16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        random_traffic(20);

        settle();
        write_regs(16'($urandom_range(0, 255)), 16'd1, 16'd16384, 16'd900,
                   16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        send_frame(MODE_SNAKE, 8'hC8, FRAME_TAIL0, FRAME_TAIL1);
        stall_long = 1'b1;
        send_ticks(40);
        settle();

        idling = 1'b0;
        random_traffic(25);

        settle();
        repeat (20) @(posedge clk);
        if (check_fails == 0 && check_pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
